FILE: sv/set_membership_table_macros.svh
// Assertion helpers used by the RTL.
`ifndef SET_MEMBERSHIP_TABLE_MACROS_SVH
`define SET_MEMBERSHIP_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SMT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SMT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/smt_pkg.sv
package smt_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2
    } smt_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } smt_state_t;

    // Flags carried by the lookup token as it walks the chain
    typedef struct packed {
        logic active;
        logic hit;
        logic free_found;
    } smt_tok_t;

    // Write broadcast to the cells at the end of a lookup
    typedef struct packed {
        logic en;
        logic set;   // 1: store value and mark valid, 0: invalidate
    } smt_wr_t;

endpackage

FILE: sv/smt_cell.sv
module smt_cell import smt_pkg::*; #(
    parameter int ELEM_WIDTH = 32,
    parameter int IDX_W      = 6,
    parameter int CELL_IDX   = 0
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  smt_tok_t              tok_in,
    input  logic [ELEM_WIDTH-1:0] tok_value_in,
    input  logic [IDX_W-1:0]      hit_idx_in,
    input  logic [IDX_W-1:0]      free_idx_in,
    output smt_tok_t              tok_out,
    output logic [ELEM_WIDTH-1:0] tok_value_out,
    output logic [IDX_W-1:0]      hit_idx_out,
    output logic [IDX_W-1:0]      free_idx_out,
    input  smt_wr_t               wr,
    input  logic [IDX_W-1:0]      wr_idx,
    input  logic [ELEM_WIDTH-1:0] wr_value
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    logic [ELEM_WIDTH-1:0] value_reg;
    logic                  valid_reg;
    smt_tok_t              tok_reg, tok_next;
    logic [ELEM_WIDTH-1:0] tok_value_reg;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  match;
    logic                  wr_here;

    assign match   = valid_reg && (value_reg == tok_value_in);
    assign wr_here = wr.en && (wr_idx == MY_IDX);

    always_comb begin
        tok_next.active     = tok_in.active;
        tok_next.hit        = tok_in.hit | match;
        tok_next.free_found = tok_in.free_found | ~valid_reg;
        // first hit / first free slot along the chain wins
        hit_idx_next  = (!tok_in.hit && match) ? MY_IDX : hit_idx_in;
        free_idx_next = (!tok_in.free_found && !valid_reg) ? MY_IDX : free_idx_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end else begin
            tok_reg <= tok_next;
            if (wr_here) begin
                valid_reg <= wr.set;
            end
        end
    end

    always_ff @(posedge aclk) begin
        tok_value_reg <= tok_value_in;
        hit_idx_reg   <= hit_idx_next;
        free_idx_reg  <= free_idx_next;
        if (wr_here && wr.set) begin
            value_reg <= wr_value;
        end
    end

    assign tok_out       = tok_reg;
    assign tok_value_out = tok_value_reg;
    assign hit_idx_out   = hit_idx_reg;
    assign free_idx_out  = free_idx_reg;

endmodule

FILE: sv/set_membership_table.sv
// Channel  | Ports                                                | Direction
// ---------+------------------------------------------------------+----------
// request  | s_valid s_ready s_cmd s_value                        | in
// result   | m_valid m_ready m_was_present m_insert_refused       | out
//          | m_element_count m_is_empty                           |
//
// One transaction in flight. After acceptance the token walks the compare chain one
// cell per cycle, the last cell's flags are captured, then the commit step writes
// the cell, loads the result register and raises m_valid.
// s_ready returns the cycle after the commit, so a new request is taken only once the
// last one has committed. Reset clears the valid bits and count at once.
// A stalled result holds the next transaction in its commit step until it frees.
`include "set_membership_table_macros.svh"

module set_membership_table import smt_pkg::*; #(
    parameter int SET_CAPACITY = 64,
    parameter int ELEM_WIDTH   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_was_present,
    output logic        m_insert_refused,
    output logic [6:0]  m_element_count,
    output logic        m_is_empty
);

    localparam int IDX_W = $clog2(SET_CAPACITY);
    localparam int CNT_W = $clog2(SET_CAPACITY + 1);

    smt_state_t state_reg, state_next;

    smt_tok_t              tok_chain  [0:SET_CAPACITY];
    logic [ELEM_WIDTH-1:0] val_chain  [0:SET_CAPACITY];
    logic [IDX_W-1:0]      hit_chain  [0:SET_CAPACITY];
    logic [IDX_W-1:0]      free_chain [0:SET_CAPACITY];

    logic [1:0]            cmd_reg;
    logic                  res_hit_reg, res_free_reg;
    logic [IDX_W-1:0]      res_hit_idx_reg, res_free_idx_reg;
    logic [ELEM_WIDTH-1:0] res_value_reg;
    logic [CNT_W-1:0]      held_count_reg, held_count_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_was_present_reg, m_insert_refused_reg, m_is_empty_reg;
    logic [6:0]            m_element_count_reg;

    logic                  in_fire, capture, commit, out_free;
    logic                  do_ins, do_rem, refused;
    logic [63:0]           value_wide;
    logic [CNT_W+6:0]      count_ext;
    smt_wr_t               wr;
    logic [IDX_W-1:0]      wr_idx;

    assign in_fire    = s_valid && s_ready;
    assign value_wide = {32'b0, s_value};

    // token entering the head of the chain
    assign tok_chain[0]  = '{active: in_fire, hit: 1'b0, free_found: 1'b0};
    assign val_chain[0]  = value_wide[ELEM_WIDTH-1:0];
    assign hit_chain[0]  = '0;
    assign free_chain[0] = '0;

    for (genvar i = 0; i < SET_CAPACITY; i++) begin : g_cell
        smt_cell #(
            .ELEM_WIDTH (ELEM_WIDTH),
            .IDX_W      (IDX_W),
            .CELL_IDX   (i)
        ) u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .tok_in        (tok_chain[i]),
            .tok_value_in  (val_chain[i]),
            .hit_idx_in    (hit_chain[i]),
            .free_idx_in   (free_chain[i]),
            .tok_out       (tok_chain[i+1]),
            .tok_value_out (val_chain[i+1]),
            .hit_idx_out   (hit_chain[i+1]),
            .free_idx_out  (free_chain[i+1]),
            .wr            (wr),
            .wr_idx        (wr_idx),
            .wr_value      (res_value_reg)
        );
    end

    assign out_free = !m_valid_reg || m_ready;
    assign do_ins   = (cmd_reg == CMD_INSERT) && !res_hit_reg && res_free_reg;
    assign refused  = (cmd_reg == CMD_INSERT) && !res_hit_reg && !res_free_reg;
    assign do_rem   = (cmd_reg == CMD_REMOVE) && res_hit_reg;

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        capture    = 1'b0;
        commit     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (tok_chain[SET_CAPACITY].active) begin
                    capture    = 1'b1;
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        wr.en           = commit && (do_ins || do_rem);
        wr.set          = do_ins;
        wr_idx          = do_ins ? res_free_idx_reg : res_hit_idx_reg;
        held_count_next = held_count_reg + CNT_W'(do_ins) - CNT_W'(do_rem);
        count_ext       = {7'b0, held_count_next};
        m_valid_next    = commit ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            held_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (commit) begin
                held_count_reg <= held_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            cmd_reg <= s_cmd;
        end
        if (capture) begin
            res_hit_reg      <= tok_chain[SET_CAPACITY].hit;
            res_free_reg     <= tok_chain[SET_CAPACITY].free_found;
            res_hit_idx_reg  <= hit_chain[SET_CAPACITY];
            res_free_idx_reg <= free_chain[SET_CAPACITY];
            res_value_reg    <= val_chain[SET_CAPACITY];
        end
        if (commit) begin
            m_was_present_reg    <= res_hit_reg;
            m_insert_refused_reg <= refused;
            m_element_count_reg  <= count_ext[6:0];
            m_is_empty_reg       <= (held_count_next == '0);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_was_present    = m_was_present_reg;
    assign m_insert_refused = m_insert_refused_reg;
    assign m_element_count  = m_element_count_reg;
    assign m_is_empty       = m_is_empty_reg;

    `SMT_ASSERT_NOW(a_tok_only_in_scan, aclk, aresetn,
        tok_chain[SET_CAPACITY].active, state_reg == ST_SCAN, "token left chain outside scan")
    `SMT_ASSERT_NOW(a_count_bound, aclk, aresetn,
        1'b1, held_count_reg <= CNT_W'(SET_CAPACITY), "element count above capacity")
    `SMT_ASSERT_NOW(a_refuse_when_full, aclk, aresetn,
        commit && refused, held_count_reg == CNT_W'(SET_CAPACITY), "insert refused with free slot")
    `SMT_ASSERT_NEXT(a_accept_starts_scan, aclk, aresetn,
        in_fire, state_reg == ST_SCAN, "accepted request did not start a scan")
    `SMT_ASSERT_NOW(a_refuse_not_present, aclk, aresetn,
        m_valid_reg && m_insert_refused_reg, !m_was_present_reg, "refused insert of held value")

endmodule

FILE: verif/set_membership_table_checker.sv
module set_membership_table_checker import smt_pkg::*; #(
    parameter int SET_CAPACITY = 64,
    parameter int ELEM_WIDTH   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [31:0] s_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_was_present,
    input  logic        m_insert_refused,
    input  logic [6:0]  m_element_count,
    input  logic        m_is_empty,
    output int          mismatches,
    output int          pending_n
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       was_present;
        logic       insert_refused;
        logic [6:0] element_count;
        logic       is_empty;
    } lookup_result_t;

    localparam logic [63:0] ELEM_MASK =
        (ELEM_WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << ELEM_WIDTH) - 64'd1);

    // shadow copy of the store
    logic [63:0]    slot_val [SET_CAPACITY];
    bit             slot_used [SET_CAPACITY];
    int             occupancy = 0;
    lookup_result_t expected_q [$];
    lookup_result_t got;
    lookup_result_t want;
    int             fails = 0;

    // Applies one command to the shadow store and returns the result it should give.
    function automatic lookup_result_t apply_op(input logic [1:0] cmd,
                                                input logic [31:0] value);
        logic [63:0]    key;
        int             hit;
        int             free_idx;
        lookup_result_t r;
        key      = {32'd0, value} & ELEM_MASK;
        hit      = -1;
        free_idx = -1;
        for (int i = 0; i < SET_CAPACITY; i++) begin
            if (slot_used[i] && slot_val[i] == key && hit < 0)
                hit = i;
            if (!slot_used[i] && free_idx < 0)
                free_idx = i;
        end
        r             = '0;
        r.was_present = (hit >= 0);
        if (cmd == CMD_INSERT) begin
            if (hit < 0) begin
                if (free_idx >= 0) begin
                    slot_val[free_idx]  = key;
                    slot_used[free_idx] = 1'b1;
                    occupancy++;
                end else begin
                    r.insert_refused = 1'b1;
                end
            end
        end else if (cmd == CMD_REMOVE) begin
            if (hit >= 0) begin
                slot_used[hit] = 1'b0;
                occupancy--;
            end
        end
        // query and the spare code leave the store alone
        r.element_count = 7'(occupancy);
        r.is_empty      = (occupancy == 0);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            foreach (slot_used[i])
                slot_used[i] = 1'b0;
            occupancy = 0;
            expected_q.delete();
            pending_n <= 0;
        end else begin
            // a result can never belong to a transaction taken on the same edge
            if (m_valid && m_ready) begin
                got = '{m_was_present, m_insert_refused, m_element_count, m_is_empty};
                if (expected_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (got.was_present !== want.was_present) begin
                        $error("was_present: expected %0d, got %0d",
                               want.was_present, got.was_present);
                        fails++;
                    end
                    if (got.insert_refused !== want.insert_refused) begin
                        $error("insert_refused: expected %0d, got %0d",
                               want.insert_refused, got.insert_refused);
                        fails++;
                    end
                    if (got.element_count !== want.element_count) begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, got.element_count);
                        fails++;
                    end
                    if (got.is_empty !== want.is_empty) begin
                        $error("is_empty: expected %0d, got %0d",
                               want.is_empty, got.is_empty);
                        fails++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_q.push_back(apply_op(s_cmd, s_value));
            pending_n <= expected_q.size();
        end
        mismatches <= fails;
    end

endmodule

FILE: verif/set_membership_table_tb.sv
module set_membership_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import smt_pkg::*;

    localparam int SET_CAPACITY = 64;
    localparam int ELEM_WIDTH   = 32;
    localparam int ITEMS        = 1750;
    localparam int POOL_SIZE    = 96;
    localparam int LONG_HOLD    = 500;
    localparam logic [1:0] CMD_SPARE = 2'd3;   // unused code, behaves as a query

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd   = CMD_QUERY;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_was_present;
    logic        m_insert_refused;
    logic [6:0]  m_element_count;
    logic        m_is_empty;
    int          mismatches;
    int          pending_n;

    logic [31:0] value_pool [POOL_SIZE];
    int          ops_sent = 0;
    bit          tx_eager = 1'b0;

    always #10 aclk = ~aclk;

    set_membership_table #(
        .SET_CAPACITY (SET_CAPACITY),
        .ELEM_WIDTH   (ELEM_WIDTH)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_was_present    (m_was_present),
        .m_insert_refused (m_insert_refused),
        .m_element_count  (m_element_count),
        .m_is_empty       (m_is_empty)
    );

    set_membership_table_checker #(
        .SET_CAPACITY (SET_CAPACITY),
        .ELEM_WIDTH   (ELEM_WIDTH)
    ) u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_value          (s_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_was_present    (m_was_present),
        .m_insert_refused (m_insert_refused),
        .m_element_count  (m_element_count),
        .m_is_empty       (m_is_empty),
        .mismatches       (mismatches),
        .pending_n        (pending_n)
    );

    task automatic offer(input logic [1:0] cmd, input logic [31:0] val);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
        ops_sent++;
    endtask

    // stop offering until every outstanding transaction has returned
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_n != 0);
    endtask

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return CMD_INSERT;
        else if (r < 7)
            return CMD_REMOVE;
        else if (r < 9)
            return CMD_QUERY;
        return CMD_SPARE;
    endfunction

    initial begin
        int ep_len;
        int base;
        int next_pause;
        foreach (value_pool[i])
            value_pool[i] = $urandom;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        value_pool[2] = 32'h8000_0000;
        value_pool[3] = 32'h0000_0001;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty store, duplicates, absent removes, spare code, value extremes
        offer(CMD_QUERY,  32'h0000_0000);
        offer(CMD_REMOVE, 32'h0000_0000);
        offer(CMD_INSERT, 32'h0000_0000);
        offer(CMD_INSERT, 32'h0000_0000);
        offer(CMD_INSERT, 32'hFFFF_FFFF);
        offer(CMD_QUERY,  32'hFFFF_FFFF);
        offer(CMD_SPARE,  32'hFFFF_FFFF);
        offer(CMD_SPARE,  32'h1234_5678);
        offer(CMD_REMOVE, 32'h8000_0000);
        offer(CMD_INSERT, 32'h8000_0000);
        offer(CMD_INSERT, 32'h7FFF_FFFF);
        offer(CMD_QUERY,  32'h7FFF_FFFE);
        offer(CMD_REMOVE, 32'h0000_0000);
        offer(CMD_REMOVE, 32'h0000_0000);
        offer(CMD_QUERY,  32'h0000_0000);
        offer(CMD_REMOVE, 32'hFFFF_FFFF);
        offer(CMD_REMOVE, 32'h8000_0000);
        offer(CMD_REMOVE, 32'h7FFF_FFFF);
        offer(CMD_QUERY,  32'h7FFF_FFFF);
        settle();

        // run past capacity, then free one slot and reuse it
        tx_eager = 1'b1;
        for (int i = 0; i < SET_CAPACITY + 6; i++)
            offer(CMD_INSERT, 32'h5A00_0000 | i);
        offer(CMD_INSERT, 32'h5A00_0000);
        offer(CMD_QUERY,  32'h5A00_0000 | SET_CAPACITY);
        offer(CMD_SPARE,  32'h5A00_0001);
        offer(CMD_REMOVE, 32'h5A00_0005);
        offer(CMD_INSERT, 32'h5A00_0000 | SET_CAPACITY);
        offer(CMD_INSERT, 32'h5A00_0000 | (SET_CAPACITY + 1));
        settle();
        for (int i = 0; i <= SET_CAPACITY + 1; i++)
            offer(CMD_REMOVE, 32'h5A00_0000 | i);
        settle();

        next_pause = ops_sent + 500;
        while (ops_sent < ITEMS) begin
            tx_eager = ($urandom_range(0, 4) == 0);
            ep_len   = $urandom_range(8, 40);
            base     = $urandom_range(0, POOL_SIZE - 1);
            case ($urandom_range(0, 5))
                0: begin
                    // walk the pool far enough to fill the store
                    for (int n = 0; n < SET_CAPACITY + 8; n++)
                        offer(CMD_INSERT, value_pool[(base + n) % POOL_SIZE]);
                end
                1: begin
                    if ($urandom_range(0, 1) == 0)
                        ep_len = POOL_SIZE;
                    for (int n = 0; n < ep_len; n++)
                        offer(CMD_REMOVE, value_pool[(base + n) % POOL_SIZE]);
                end
                2, 3: begin
                    for (int n = 0; n < ep_len; n++)
                        offer(pick_cmd(), value_pool[$urandom_range(0, POOL_SIZE - 1)]);
                end
                4: begin
                    for (int n = 0; n < ep_len; n++)
                        offer(pick_cmd(), $urandom);
                end
                default: begin
                    // near misses: one bit away from a held candidate
                    for (int n = 0; n < ep_len; n++)
                        offer(pick_cmd(), value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          ^ (32'd1 << $urandom_range(0, 31)));
                end
            endcase
            if (ops_sent >= next_pause) begin
                settle();
                next_pause += 500;
            end
        end

        settle();
        repeat (SET_CAPACITY + 8) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // result side: random stalls, eager stretches and two long hold-offs
    initial begin
        int hold;
        int taken;
        bit rx_eager;
        taken    = 0;
        rx_eager = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (taken % 100 == 0)
                rx_eager = ($urandom_range(0, 3) == 0);
            if (taken == 300 || taken == 1200)
                hold = LONG_HOLD;
            else
                hold = rx_eager ? 0 : $urandom_range(0, 15);
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin
        #25_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
